// File: hw/rtl/ibt_pkg.sv
// Shared constants, codes and types of the interval blocklist table.
package ibt_pkg;

   localparam int MAX_RANGES  = 1024;
   localparam int IDX_W       = $clog2(MAX_RANGES);
   localparam int CNT_W       = $clog2(MAX_RANGES + 1);
   localparam int MEM_AW      = IDX_W + 1;
   localparam int TABLE_DEPTH = 2 << IDX_W;

   localparam int ADDR_W   = 32;
   localparam int ENTRY_W  = 2 * ADDR_W;
   localparam int SUM_W    = 33;
   localparam int STATUS_W = 2;
   localparam int RANGES_W = 11;

   localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = 32'hffff_ffff;
   localparam logic [SUM_W-1:0]  FULL_SUM      = 33'h1_0000_0000;

   localparam logic CMD_BLOCK   = 1'b0;
   localparam logic CMD_RESTART = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ORDER = 2'd2;

   typedef struct packed {
      logic              cmd;
      logic [ADDR_W-1:0] block_low;
      logic [ADDR_W-1:0] block_high;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   lowest_allowed;
      logic                none_allowed;
      logic [SUM_W-1:0]    allowed_count;
      logic [RANGES_W-1:0] ranges_in_use;
   } result_type;

   typedef struct packed {
      logic               en;
      logic [MEM_AW-1:0]  addr;
      logic [ENTRY_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [MEM_AW-1:0] addr;
   } mem_rd_type;

endpackage

// File: hw/rtl/ibt_channels.sv
// Valid/ready channel interfaces for requests and responses.
interface ibt_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [ibt_pkg::ADDR_W-1:0] block_low;
   logic [ibt_pkg::ADDR_W-1:0] block_high;

   modport source (output valid, output cmd, output block_low, output block_high,
                   input ready);
   modport sink (input valid, input cmd, input block_low, input block_high,
                 output ready);
endinterface

interface ibt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ibt_pkg::STATUS_W-1:0] status;
   logic [ibt_pkg::ADDR_W-1:0]   lowest_allowed;
   logic                        none_allowed;
   logic [ibt_pkg::SUM_W-1:0]    allowed_count;
   logic [ibt_pkg::RANGES_W-1:0] ranges_in_use;

   modport source (output valid, output status, output lowest_allowed,
                   output none_allowed, output allowed_count, output ranges_in_use,
                   input ready);
   modport sink (input valid, input status, input lowest_allowed,
                 input none_allowed, input allowed_count, input ranges_in_use,
                 output ready);
endinterface

// File: hw/rtl/ibt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ibt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/ibt_scan.sv
// Sequencer that copies the range table from one bank to the other, subtracting a range, or restarts it in place.
module ibt_scan (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  ibt_pkg::req_type             in_word,
   output logic                         res_valid,
   input  logic                         res_take,
   output ibt_pkg::result_type          res_word,
   output ibt_pkg::mem_wr_type          mem_wr,
   output ibt_pkg::mem_rd_type          mem_rd,
   input  logic [ibt_pkg::ENTRY_W-1:0]  mem_rd_data
);
   import ibt_pkg::*;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_PROC  = 3'd3;
   localparam logic [2:0] ST_SPLIT = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic                bank_ff, bank_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ADDR_W-1:0]   lowest_ff, lowest_in;
   logic [ADDR_W-1:0]   lo_ff, lo_in;
   logic [ADDR_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [SUM_W-1:0]    new_sum_ff, new_sum_in;
   logic [ADDR_W-1:0]   new_lowest_ff, new_lowest_in;
   logic [SUM_W-1:0]    len_ff, len_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                swap_ff, swap_in;
   logic [ADDR_W-1:0]   split_end_ff, split_end_in;

   logic [ADDR_W-1:0] ent_s, ent_e;
   logic [ADDR_W-1:0] w_s, w_e;
   logic              w_en;
   logic              is_ok;

   assign ent_s = mem_rd_data[ENTRY_W-1:ADDR_W];
   assign ent_e = mem_rd_data[ADDR_W-1:0];
   assign is_ok = (status_ff == STATUS_OK);

   always_comb begin
      state_in      = state_ff;
      bank_in       = bank_ff;
      total_in      = total_ff;
      sum_in        = sum_ff;
      lowest_in     = lowest_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      new_sum_in    = new_sum_ff + len_ff;
      new_lowest_in = new_lowest_ff;
      len_in        = '0;
      status_in     = status_ff;
      swap_in       = swap_ff;
      split_end_in  = split_end_ff;
      w_en          = 1'b0;
      w_s           = ent_s;
      w_e           = ent_e;
      in_ready      = 1'b0;
      res_valid     = 1'b0;
      mem_rd.en     = 1'b0;
      mem_rd.addr   = {bank_ff, rd_idx_ff[IDX_W-1:0]};
      mem_wr.en     = 1'b0;
      mem_wr.addr   = {~bank_ff, wr_idx_ff[IDX_W-1:0]};
      mem_wr.data   = {w_s, w_e};

      unique case (state_ff)
         ST_INIT: begin
            // Load the full range into entry 0 of bank 0 once after reset.
            mem_wr.en   = 1'b1;
            mem_wr.addr = '0;
            mem_wr.data = {{ADDR_W{1'b0}}, ADDR_ALL_ONES};
            state_in    = ST_IDLE;
         end
         ST_IDLE: begin
            in_ready   = 1'b1;
            new_sum_in = new_sum_ff;
            if (in_valid) begin
               lo_in         = in_word.block_low;
               hi_in         = in_word.block_high;
               rd_idx_in     = '0;
               wr_idx_in     = '0;
               new_sum_in    = '0;
               new_lowest_in = '0;
               status_in     = STATUS_OK;
               swap_in       = 1'b1;
               if (in_word.cmd == CMD_RESTART) begin
                  // Restart rewrites entry 0 of the active bank in place.
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = {bank_ff, {IDX_W{1'b0}}};
                  mem_wr.data = {{ADDR_W{1'b0}}, ADDR_ALL_ONES};
                  wr_idx_in   = CNT_W'(1);
                  new_sum_in  = FULL_SUM;
                  swap_in     = 1'b0;
                  state_in    = ST_DONE;
               end else if (in_word.block_low > in_word.block_high) begin
                  status_in = STATUS_ORDER;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (rd_idx_ff == total_ff) begin
               state_in = ST_DONE;
            end else begin
               mem_rd.en = 1'b1;
               rd_idx_in = rd_idx_ff + CNT_W'(1);
               state_in  = ST_PROC;
            end
         end
         ST_PROC: begin
            state_in = ST_READ;
            if (hi_ff < ent_s || lo_ff > ent_e) begin
               w_en = 1'b1;
            end else if (lo_ff > ent_s && hi_ff < ent_e) begin
               if (total_ff >= CNT_W'(MAX_RANGES)) begin
                  // The new bank is simply never committed.
                  status_in = STATUS_FULL;
                  state_in  = ST_DONE;
               end else begin
                  w_en         = 1'b1;
                  w_e          = lo_ff - ADDR_W'(1);
                  split_end_in = ent_e;
                  state_in     = ST_SPLIT;
               end
            end else if (lo_ff <= ent_s && hi_ff >= ent_e) begin
               w_en = 1'b0;
            end else if (lo_ff <= ent_s) begin
               w_en = 1'b1;
               w_s  = hi_ff + ADDR_W'(1);
            end else begin
               w_en = 1'b1;
               w_e  = lo_ff - ADDR_W'(1);
            end
         end
         ST_SPLIT: begin
            w_en     = 1'b1;
            w_s      = hi_ff + ADDR_W'(1);
            w_e      = split_end_ff;
            state_in = ST_READ;
         end
         ST_DONE: begin
            res_valid = 1'b1;
            if (res_take) begin
               if (is_ok) begin
                  total_in  = wr_idx_ff;
                  sum_in    = new_sum_ff;
                  lowest_in = new_lowest_ff;
                  bank_in   = bank_ff ^ swap_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (w_en) begin
         mem_wr.en   = 1'b1;
         mem_wr.data = {w_s, w_e};
         wr_idx_in   = wr_idx_ff + CNT_W'(1);
         len_in      = {1'b0, w_e} - {1'b0, w_s} + SUM_W'(1);
         if (wr_idx_ff == '0) begin
            new_lowest_in = w_s;
         end
      end
   end

   always_comb begin
      res_word.status = status_ff;
      if (is_ok) begin
         res_word.lowest_allowed = new_lowest_ff;
         res_word.none_allowed   = (wr_idx_ff == '0);
         res_word.allowed_count  = new_sum_ff;
         res_word.ranges_in_use  = RANGES_W'(wr_idx_ff);
      end else begin
         res_word.lowest_allowed = lowest_ff;
         res_word.none_allowed   = (total_ff == '0);
         res_word.allowed_count  = sum_ff;
         res_word.ranges_in_use  = RANGES_W'(total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_INIT;
         bank_ff   <= 1'b0;
         total_ff  <= CNT_W'(1);
         sum_ff    <= FULL_SUM;
         lowest_ff <= '0;
         len_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         bank_ff   <= bank_in;
         total_ff  <= total_in;
         sum_ff    <= sum_in;
         lowest_ff <= lowest_in;
         len_ff    <= len_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      new_sum_ff    <= new_sum_in;
      new_lowest_ff <= new_lowest_in;
      status_ff     <= status_in;
      swap_ff       <= swap_in;
      split_end_ff  <= split_end_in;
   end

endmodule

// File: hw/rtl/interval_blocklist_table.sv
// Top level of the interval blocklist table: range table sequencer, table RAM and response register.
//
//   channel  direction  word
//   req      in         cmd, block_low, block_high
//   rsp      out        status, lowest_allowed, none_allowed, allowed_count, ranges_in_use
//
// A block word handles each of the N ranges in use with a RAM read state on the single read
// port and an update state, plus a split state when a range splits. Restart and low-above-high
// words go straight from idle to the done state. The table sits in two RAM banks; a pass
// reads the active bank and writes the other, which becomes active when the word succeeds.
// An init state after reset loads the full range before the first word is accepted.
// A pending response does not block a new request; a finished word waits only on rsp.
module interval_blocklist_table (
   input  logic       clock,
   input  logic       reset,
   ibt_req_if.sink    req_port,
   ibt_rsp_if.source  rsp_port
);
   import ibt_pkg::*;

   req_type    req_word;
   result_type res_word;
   logic       res_valid;
   logic       res_take;
   mem_wr_type mem_wr;
   mem_rd_type mem_rd;
   logic [ENTRY_W-1:0] mem_rd_data;

   result_type rsp_word_ff, rsp_word_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_word.cmd        = req_port.cmd;
   assign req_word.block_low  = req_port.block_low;
   assign req_word.block_high = req_port.block_high;

   assign res_take = !rsp_valid_ff || rsp_port.ready;

   ibt_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_port.valid),
      .in_ready    (req_port.ready),
      .in_word     (req_word),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res_word    (res_word),
      .mem_wr      (mem_wr),
      .mem_rd      (mem_rd),
      .mem_rd_data (mem_rd_data)
   );

   ibt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr.en),
      .wr_addr (mem_wr.addr),
      .wr_data (mem_wr.data),
      .rd_en   (mem_rd.en),
      .rd_addr (mem_rd.addr),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_take) begin
         rsp_word_in  = res_word;
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.status         = rsp_word_ff.status;
   assign rsp_port.lowest_allowed = rsp_word_ff.lowest_allowed;
   assign rsp_port.none_allowed   = rsp_word_ff.none_allowed;
   assign rsp_port.allowed_count  = rsp_word_ff.allowed_count;
   assign rsp_port.ranges_in_use  = rsp_word_ff.ranges_in_use;

endmodule

// File: dv/testbench.sv
// Self-checking testbench of the interval blocklist table with its own range table predictor.
module testbench;
   import ibt_pkg::*;

   localparam int STALL_LIMIT   = 20000;
   localparam int DRAIN_CYCLES  = 2 * MAX_RANGES + 16;
   localparam int RANDOM_WORDS  = 267;
   localparam int HOLD_AT       = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int DIRECTED_ROWS = 23;
   localparam int SHOWN_ERRORS  = 10;

   typedef struct {
      req_type    word;
      bit         typed;
      result_type report;
   } directed_row_type;

   logic clock;
   logic reset;

   ibt_req_if req_chan ();
   ibt_rsp_if rsp_chan ();

   interval_blocklist_table i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_chan),
      .rsp_port (rsp_chan)
   );

   // Private copy of the allowed range table.
   logic [ADDR_W-1:0] span_lo [MAX_RANGES];
   logic [ADDR_W-1:0] span_hi [MAX_RANGES];
   int                span_count;

   result_type pending_reports [$];
   int         report_errors;
   int         words_sent;
   int         quiet_cycles;
   bit         sender_steady;

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{'{CMD_RESTART, 32'h0, 32'h0}, 1'b1, '{STATUS_OK, 32'h0, 1'b0, FULL_SUM, 11'd1}},
      '{'{CMD_BLOCK, 32'h5, 32'h3}, 1'b1, '{STATUS_ORDER, 32'h0, 1'b0, FULL_SUM, 11'd1}},
      '{'{CMD_BLOCK, 32'h0, 32'h0}, 1'b1,
        '{STATUS_OK, 32'h1, 1'b0, 33'h0_ffff_ffff, 11'd1}},
      '{'{CMD_BLOCK, ADDR_ALL_ONES, ADDR_ALL_ONES}, 1'b1,
        '{STATUS_OK, 32'h1, 1'b0, 33'h0_ffff_fffe, 11'd1}},
      '{'{CMD_BLOCK, 32'd100, 32'd200}, 1'b0, '0},
      '{'{CMD_BLOCK, 32'd150, 32'd160}, 1'b0, '0},
      '{'{CMD_BLOCK, 32'd50, 32'd250}, 1'b0, '0},
      '{'{CMD_BLOCK, 32'h1000_0000, 32'h7fff_ffff}, 1'b0, '0},
      '{'{CMD_BLOCK, ADDR_ALL_ONES, 32'h0}, 1'b0, '0},
      '{'{CMD_RESTART, ADDR_ALL_ONES, 32'h0}, 1'b1,
        '{STATUS_OK, 32'h0, 1'b0, FULL_SUM, 11'd1}},
      '{'{CMD_BLOCK, 32'h0, ADDR_ALL_ONES}, 1'b1, '{STATUS_OK, 32'h0, 1'b1, 33'h0, 11'd0}},
      '{'{CMD_BLOCK, 32'h7, 32'h7}, 1'b1, '{STATUS_OK, 32'h0, 1'b1, 33'h0, 11'd0}},
      '{'{CMD_BLOCK, ADDR_ALL_ONES, 32'h0}, 1'b1,
        '{STATUS_ORDER, 32'h0, 1'b1, 33'h0, 11'd0}},
      '{'{CMD_RESTART, 32'h1234, 32'h5678}, 1'b1,
        '{STATUS_OK, 32'h0, 1'b0, FULL_SUM, 11'd1}},
      '{'{CMD_BLOCK, 32'h1, 32'hffff_fffe}, 1'b1, '{STATUS_OK, 32'h0, 1'b0, 33'h2, 11'd2}},
      '{'{CMD_BLOCK, 32'h0, 32'h0}, 1'b1, '{STATUS_OK, ADDR_ALL_ONES, 1'b0, 33'h1, 11'd1}},
      '{'{CMD_BLOCK, 32'h0, 32'hffff_fffe}, 1'b1,
        '{STATUS_OK, ADDR_ALL_ONES, 1'b0, 33'h1, 11'd1}},
      '{'{CMD_RESTART, 32'h0, 32'h0}, 1'b1, '{STATUS_OK, 32'h0, 1'b0, FULL_SUM, 11'd1}},
      '{'{CMD_BLOCK, 32'h1000, 32'h1fff}, 1'b0, '0},
      '{'{CMD_BLOCK, 32'h3000, 32'h3fff}, 1'b0, '0},
      '{'{CMD_BLOCK, 32'h5000, 32'h5fff}, 1'b0, '0},
      '{'{CMD_BLOCK, 32'h0800, 32'h6800}, 1'b0, '0},
      '{'{CMD_BLOCK, 32'h0, 32'h6800}, 1'b0, '0}
   };

   function automatic void restart_spans();
      span_count = 1;
      span_lo[0] = '0;
      span_hi[0] = ADDR_ALL_ONES;
   endfunction

   // Returns the status code; on success, removes [lo, hi] from every entry it overlaps.
   function automatic logic [STATUS_W-1:0] cut_range(logic [ADDR_W-1:0] lo,
                                                     logic [ADDR_W-1:0] hi);
      int k;
      int j;
      if (lo > hi) return STATUS_ORDER;
      for (k = 0; k < span_count; k++) begin
         if (lo > span_lo[k] && hi < span_hi[k]) begin
            if (span_count >= MAX_RANGES) return STATUS_FULL;
            break;
         end
      end
      k = 0;
      while (k < span_count) begin
         if (hi < span_lo[k] || lo > span_hi[k]) begin
            k++;
         end else if (lo > span_lo[k] && hi < span_hi[k]) begin
            for (j = span_count; j > k; j--) begin
               span_lo[j] = span_lo[j-1];
               span_hi[j] = span_hi[j-1];
            end
            span_hi[k]   = lo - 1;
            span_lo[k+1] = hi + 1;
            span_count++;
            k += 2;
         end else if (lo <= span_lo[k] && hi >= span_hi[k]) begin
            for (j = k; j < span_count - 1; j++) begin
               span_lo[j] = span_lo[j+1];
               span_hi[j] = span_hi[j+1];
            end
            span_count--;
         end else begin
            if (lo <= span_lo[k]) span_lo[k] = hi + 1;
            else span_hi[k] = lo - 1;
            k++;
         end
      end
      return STATUS_OK;
   endfunction

   function automatic result_type apply_word(req_type w);
      result_type        r;
      longint unsigned   total;
      int                k;
      r.status = STATUS_OK;
      if (w.cmd == CMD_RESTART) restart_spans();
      else r.status = cut_range(w.block_low, w.block_high);
      total = 0;
      for (k = 0; k < span_count; k++)
         total += 64'(span_hi[k]) - 64'(span_lo[k]) + 1;
      r.lowest_allowed = (span_count > 0) ? span_lo[0] : '0;
      r.none_allowed   = (span_count == 0);
      r.allowed_count  = total[SUM_W-1:0];
      r.ranges_in_use  = RANGES_W'(span_count);
      return r;
   endfunction

   // Favors the low corner, the top corner and the edges of ranges now in the table.
   function automatic logic [ADDR_W-1:0] pick_addr();
      int                k;
      logic [ADDR_W-1:0] a;
      case ($urandom_range(0, 9))
         0: a = '0;
         1: a = ADDR_ALL_ONES;
         2, 3, 4: a = $urandom_range(0, 4095);
         5, 6: a = $urandom;
         7: a = ADDR_ALL_ONES - $urandom_range(0, 4095);
         default: begin
            if (span_count == 0) begin
               a = $urandom;
            end else begin
               k = $urandom_range(0, span_count - 1);
               a = ($urandom_range(0, 1) ? span_lo[k] : span_hi[k]) + $urandom_range(0, 2) - 1;
            end
         end
      endcase
      return a;
   endfunction

   function automatic req_type random_word();
      req_type           w;
      int                sel;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      logic [ADDR_W-1:0] t;
      sel   = $urandom_range(0, 99);
      w.cmd = CMD_BLOCK;
      a     = pick_addr();
      b     = pick_addr();
      if (sel < 4) begin
         w.cmd = CMD_RESTART;
         a = $urandom;
         b = $urandom;
      end else if (sel < 10) begin
         // Malformed word: the larger address goes first.
         if (a < b) begin
            t = a;
            a = b;
            b = t;
         end else if (a == b) begin
            if (a == '0) a = 1;
            else b = a - 1;
         end
      end else if (sel < 65) begin
         b = a + ((sel < 45) ? $urandom_range(0, 15) : $urandom_range(0, 4095));
         if (b < a) b = ADDR_ALL_ONES;
      end else if (a > b) begin
         t = a;
         a = b;
         b = t;
      end
      w.block_low  = a;
      w.block_high = b;
      return w;
   endfunction

   task automatic send_word(input req_type w, input bit typed, input result_type want);
      int         gap;
      result_type predicted;
      gap = sender_steady ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.cmd        <= w.cmd;
      req_chan.block_low  <= w.block_low;
      req_chan.block_high <= w.block_high;
      do @(posedge clock); while (!req_chan.ready);
      predicted = apply_word(w);
      pending_reports.insert(pending_reports.size(), typed ? want : predicted);
      words_sent++;
      if (words_sent % 32 == 0) sender_steady = ($urandom_range(0, 3) == 0);
   endtask

   always #5 clock = ~clock;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Word source: directed table, then random words.
   initial begin
      int         n;
      req_type    w;
      result_type none;
      none = '0;
      req_chan.valid      <= 1'b0;
      req_chan.cmd        <= CMD_BLOCK;
      req_chan.block_low  <= '0;
      req_chan.block_high <= '0;
      restart_spans();
      @(posedge clock);
      while (reset) @(posedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++)
         send_word(directed_rows[n].word, directed_rows[n].typed, directed_rows[n].report);

      for (n = 0; n < RANDOM_WORDS; n++) begin
         w = random_word();
         send_word(w, 1'b0, none);
      end
      req_chan.valid <= 1'b0;

      wait (pending_reports.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (report_errors == 0 && pending_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Result sink with random stalls and one long hold-off that backs up the block.
   initial begin
      int         stall;
      int         seen;
      bit         steady;
      result_type got;
      result_type want;
      seen   = 0;
      steady = 1'b0;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (seen == HOLD_AT) stall = HOLD_CYCLES;
         else stall = steady ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         got.status         = rsp_chan.status;
         got.lowest_allowed = rsp_chan.lowest_allowed;
         got.none_allowed   = rsp_chan.none_allowed;
         got.allowed_count  = rsp_chan.allowed_count;
         got.ranges_in_use  = rsp_chan.ranges_in_use;
         if (pending_reports.size() == 0) begin
            report_errors++;
            if (report_errors <= SHOWN_ERRORS)
               $display("report %0d arrived with no word outstanding", seen);
         end else begin
            want = pending_reports.pop_front();
            if (got !== want) begin
               report_errors++;
               if (report_errors <= SHOWN_ERRORS)
                  $display({"report %0d mismatch: expected status %0d lowest %h none %0d ",
                            "count %h ranges %0d, got status %0d lowest %h none %0d ",
                            "count %h ranges %0d"},
                           seen, want.status, want.lowest_allowed, want.none_allowed,
                           want.allowed_count, want.ranges_in_use, got.status,
                           got.lowest_allowed, got.none_allowed, got.allowed_count,
                           got.ranges_in_use);
            end
         end
         seen++;
         if (seen % 32 == 0) steady = ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

endmodule

// File: sim.f
hw/rtl/ibt_pkg.sv
hw/rtl/ibt_channels.sv
hw/rtl/ibt_ram.sv
hw/rtl/ibt_scan.sv
hw/rtl/interval_blocklist_table.sv
dv/testbench.sv
